// ===== rtl/fpw_pkg.sv =====
// ----------------------------------------------------------------------------
// fpw_pkg
// Types and codes shared by the four-level page walker modules: channel
// payloads, the classified queue entry and the result status codes.
// ----------------------------------------------------------------------------
package fpw_pkg;

   // request func codes
   localparam logic FUNC_TRANSLATE = 1'b0;
   localparam logic FUNC_RESPONSE  = 1'b1;

   // result kinds
   localparam logic KIND_FETCH = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   // configuration register indexes
   localparam logic CSR_ROOT  = 1'b0;
   localparam logic CSR_VALID = 1'b1;

   // finished-walk status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_UNUSABLE    = 3'd1;
   localparam logic [2:0] ST_NONCANON    = 3'd2;
   localparam logic [2:0] ST_UNREADABLE  = 3'd3;
   localparam logic [2:0] ST_NOTPRESENT  = 3'd4;
   localparam logic [2:0] ST_PROTOCOL    = 3'd5;

   // table levels, 0 is the top
   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   localparam int FRAME_W = 40;  // physical address bits 51:12
   localparam int VA_W    = 48;
   localparam int PA_W    = 52;

   typedef struct packed {
      logic        func;
      logic [63:0] virtual_address;
      logic [63:0] entry_value;
      logic        entry_read_ok;
   } req_type;

   typedef struct packed {
      logic            result_kind;
      logic [PA_W-1:0] fetch_address;
      logic [1:0]      fetch_level;
      logic [2:0]      status;
      logic [PA_W-1:0] physical_address;
      logic            large_page;
   } rsp_type;

   // item after classification, as it sits in the queue
   typedef struct packed {
      logic               is_response;
      logic               noncanon;
      logic [VA_W-1:0]    va;
      logic               read_ok;
      logic               present;
      logic               page_size;
      logic [FRAME_W-1:0] frame;
   } cls_type;

endpackage

// ===== rtl/fpw_front.sv =====
// ----------------------------------------------------------------------------
// fpw_front
// Accepts request items, classifies them (canonical check, entry flags and
// frame) and holds them in a two-entry queue for the walk engine.
// ----------------------------------------------------------------------------
module fpw_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fpw_pkg::req_type req_item,
   output logic            head_valid,
   output fpw_pkg::cls_type head,
   input  logic            head_pop
);
   import fpw_pkg::*;

   cls_type    cls;
   cls_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic [16:0] va_high;

   assign va_high = req_item.virtual_address[63:47];

   always_comb begin
      cls.is_response = (req_item.func == FUNC_RESPONSE);
      cls.noncanon    = (va_high != '0) && (va_high != '1);
      cls.va          = req_item.virtual_address[VA_W-1:0];
      cls.read_ok     = req_item.entry_read_ok;
      cls.present     = req_item.entry_value[0];
      cls.page_size   = req_item.entry_value[7];
      cls.frame       = req_item.entry_value[51:12];
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push     ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !head_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/fpw_back.sv =====
// ----------------------------------------------------------------------------
// fpw_back
// Walk engine: holds walk state, turns each classified item into a fetch
// or a finished result, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module fpw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fpw_pkg::FRAME_W-1:0]   root_base,
   input  logic                          memory_valid,
   input  logic                          head_valid,
   input  fpw_pkg::cls_type              head,
   output logic                          head_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fpw_pkg::rsp_type              rsp_item
);
   import fpw_pkg::*;

   logic            busy_ff, busy_in;
   logic [1:0]      level_ff, level_in;
   logic [VA_W-1:0] pending_ff, pending_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_ff, result;
   logic            usable;
   logic [1:0]      next_level;
   logic [8:0]      next_index;

   assign usable     = memory_valid && (root_base != '0);
   assign head_pop   = head_valid && (!out_valid_ff || rsp_ready);
   assign next_level = level_ff + 2'd1;

   always_comb begin
      case (next_level)
         LVL_PML4: next_index = pending_ff[47:39];
         LVL_PDPT: next_index = pending_ff[38:30];
         LVL_PD:   next_index = pending_ff[29:21];
         LVL_PT:   next_index = pending_ff[20:12];
         default:  next_index = pending_ff[20:12];
      endcase
   end

   always_comb begin
      busy_in    = busy_ff;
      level_in   = level_ff;
      pending_in = pending_ff;
      result     = '0;
      result.result_kind = KIND_DONE;
      if (!head.is_response) begin
         busy_in = 1'b0;
         if (!usable) begin
            result.status = ST_UNUSABLE;
         end else if (head.noncanon) begin
            result.status = ST_NONCANON;
         end else begin
            busy_in    = 1'b1;
            level_in   = LVL_PML4;
            pending_in = head.va;
            result.result_kind   = KIND_FETCH;
            result.fetch_level   = LVL_PML4;
            // base is 4KB aligned, so the add is a concatenation
            result.fetch_address = {root_base, head.va[47:39], 3'b000};
         end
      end else if (!busy_ff) begin
         result.status = ST_PROTOCOL;
      end else if (!head.read_ok) begin
         busy_in       = 1'b0;
         result.status = ST_UNREADABLE;
      end else if (!head.present) begin
         busy_in       = 1'b0;
         result.status = ST_NOTPRESENT;
      end else if (level_ff == LVL_PDPT && head.page_size) begin
         busy_in                 = 1'b0;
         result.large_page       = 1'b1;
         result.physical_address = {head.frame[39:18], pending_ff[29:0]};
      end else if (level_ff == LVL_PD && head.page_size) begin
         busy_in                 = 1'b0;
         result.large_page       = 1'b1;
         result.physical_address = {head.frame[39:9], pending_ff[20:0]};
      end else if (level_ff == LVL_PT) begin
         busy_in                 = 1'b0;
         result.physical_address = {head.frame, pending_ff[11:0]};
      end else begin
         level_in             = next_level;
         result.result_kind   = KIND_FETCH;
         result.fetch_level   = next_level;
         result.fetch_address = {head.frame, next_index, 3'b000};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (head_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         level_ff     <= 2'd0;
         pending_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (head_pop) begin
            busy_ff    <= busy_in;
            level_ff   <= level_in;
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

`ifndef SYNTHESIS
   a_fetch_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.result_kind == KIND_FETCH) |->
         (rsp_item.status == ST_OK && rsp_item.physical_address == '0))
      else $error("fetch result carries completion fields");
   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      (head_pop && result.result_kind == KIND_DONE && head.is_response) |=> !busy_ff)
      else $error("walk still busy after finishing");
   a_fetch_level: assert property (@(posedge clock) disable iff (reset)
      (head_pop && result.result_kind == KIND_FETCH) |=>
         (busy_ff && rsp_item.fetch_level == level_ff))
      else $error("fetch level differs from walk level");
   a_protocol_keeps: assert property (@(posedge clock) disable iff (reset)
      (head_pop && head.is_response && !busy_ff) |=> !busy_ff)
      else $error("protocol error changed walk state");
`endif

endmodule

// ===== rtl/four_level_page_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_walker
// Translates a 64-bit virtual address through four-level paging, one table
// entry fetch per level, with a classifying front end and a walk engine.
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_ready      req_item (req_type)
//   rsp_      out        rsp_valid / rsp_ready      rsp_item (rsp_type)
//   csr_      in         csr_write_enable           csr_index, csr_write_data
//
// One item per cycle sustained while results are taken; an accepted item
// passes a queue slot and then the result register. The walk engine's state
// update sets that rate. Reset is synchronous and empties queue and result
// register and returns the walker to idle. A stalled result holds the walk
// engine; the two-entry queue then fills and drops req_ready.
// ----------------------------------------------------------------------------
module four_level_page_walker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fpw_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fpw_pkg::rsp_type rsp_item,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [63:0]      csr_write_data
);
   import fpw_pkg::*;

   logic [FRAME_W-1:0] root_base_ff;
   logic               memory_valid_ff;
   logic               head_valid;
   logic               head_pop;
   cls_type            head;

   // only bits 51:12 of the root register are ever used
   always_ff @(posedge clock) begin
      if (reset) begin
         root_base_ff    <= '0;
         memory_valid_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROOT:  root_base_ff    <= csr_write_data[51:12];
            CSR_VALID: memory_valid_ff <= csr_write_data[0];
            default:   root_base_ff    <= root_base_ff;
         endcase
      end
   end

   fpw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop)
   );

   fpw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .root_base    (root_base_ff),
      .memory_valid (memory_valid_ff),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item)
   );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for four_level_page_walker. A shadow walker predicts
// each result from the accepted items and the register writes. Stimulus is
// directed register extremes and walk endings, then random walks under random
// idling on both channels, a long result stall and drained phase changes.
// ----------------------------------------------------------------------------
module testbench;
   import fpw_pkg::*;

   localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam int ENTRY_P  = 0;
   localparam int ENTRY_PS = 7;

   localparam int RESULT_LATENCY = 2;
   localparam int CYCLE_LIMIT    = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_item;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_item;
   logic        csr_write_enable;
   logic        csr_index;
   logic [63:0] csr_write_data;

   // shadow copy of the walker
   logic [63:0] root_shadow;
   logic        mem_valid_shadow;
   logic        walk_active;
   logic [1:0]  walk_lvl;
   logic [47:0] walk_va;

   rsp_type expected_results[$];

   int  mismatch_count = 0;
   int  items_sent     = 0;
   int  fetch_count    = 0;
   int  large_count    = 0;
   int  status_count[6];
   int  cycle_count    = 0;
   int  rsp_hold_cycles = 0;
   bit  idle_enable    = 1'b1;

   four_level_page_walker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // byte offset of the entry for va within the table at level lvl
   function automatic logic [63:0] table_offset(input logic [47:0] va, input logic [1:0] lvl);
      logic [8:0] idx;
      idx = 9'(va >> (39 - 9 * lvl));
      return {52'd0, idx, 3'b000};
   endfunction

   function automatic rsp_type predict_walk_step(input req_type it);
      rsp_type     r;
      logic [63:0] base;
      logic [63:0] frame;
      r = '0;
      r.result_kind = KIND_DONE;
      r.status = ST_OK;
      if (it.func == FUNC_TRANSLATE) begin
         base = root_shadow & FRAME_MASK;
         walk_active = 1'b0;
         if (!mem_valid_shadow || base == 64'd0) begin
            r.status = ST_UNUSABLE;
         end else if (it.virtual_address[63:47] != '0 && it.virtual_address[63:47] != '1) begin
            r.status = ST_NONCANON;
         end else begin
            walk_va = it.virtual_address[47:0];
            walk_lvl = LVL_PML4;
            walk_active = 1'b1;
            r.result_kind = KIND_FETCH;
            r.fetch_address = PA_W'(base + table_offset(walk_va, LVL_PML4));
            r.fetch_level = LVL_PML4;
         end
      end else if (!walk_active) begin
         r.status = ST_PROTOCOL;
      end else begin
         frame = it.entry_value & FRAME_MASK;
         if (!it.entry_read_ok) begin
            walk_active = 1'b0;
            r.status = ST_UNREADABLE;
         end else if (!it.entry_value[ENTRY_P]) begin
            walk_active = 1'b0;
            r.status = ST_NOTPRESENT;
         end else if (walk_lvl == LVL_PDPT && it.entry_value[ENTRY_PS]) begin
            walk_active = 1'b0;
            r.physical_address = {frame[51:30], walk_va[29:0]};
            r.large_page = 1'b1;
         end else if (walk_lvl == LVL_PD && it.entry_value[ENTRY_PS]) begin
            walk_active = 1'b0;
            r.physical_address = {frame[51:21], walk_va[20:0]};
            r.large_page = 1'b1;
         end else if (walk_lvl == LVL_PT) begin
            walk_active = 1'b0;
            r.physical_address = {frame[51:12], walk_va[11:0]};
         end else begin
            walk_lvl = walk_lvl + 2'd1;
            r.result_kind = KIND_FETCH;
            r.fetch_address = PA_W'(frame + table_offset(walk_va, walk_lvl));
            r.fetch_level = walk_lvl;
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // track register writes and accepted items, check each result in order
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         root_shadow = '0;
         mem_valid_shadow = 1'b0;
         walk_active = 1'b0;
         walk_lvl = LVL_PML4;
         walk_va = '0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ROOT:  root_shadow = csr_write_data;
               CSR_VALID: mem_valid_shadow = csr_write_data[0];
               default:   ;
            endcase
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_walk_step(req_item));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no item pending: kind %0h status %0h",
                      rsp_item.result_kind, rsp_item.status);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_kind", 64'(want.result_kind),
                           64'(rsp_item.result_kind));
               check_field("fetch_address", 64'(want.fetch_address),
                           64'(rsp_item.fetch_address));
               check_field("fetch_level", 64'(want.fetch_level),
                           64'(rsp_item.fetch_level));
               check_field("status", 64'(want.status), 64'(rsp_item.status));
               check_field("physical_address", 64'(want.physical_address),
                           64'(rsp_item.physical_address));
               check_field("large_page", 64'(want.large_page),
                           64'(rsp_item.large_page));
               if (want.result_kind == KIND_FETCH)
                  fetch_count++;
               else
                  status_count[want.status]++;
               if (want.large_page)
                  large_count++;
            end
         end
      end
   end

   // result side: a requested hold-off wins over random idling
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready = !(idle_enable && $urandom_range(99) < 24);
      end
   end

   function automatic req_type make_translate(input logic [63:0] va);
      req_type it;
      it.func = FUNC_TRANSLATE;
      it.virtual_address = va;
      it.entry_value = {$urandom, $urandom};
      it.entry_read_ok = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic req_type make_response(input logic [63:0] entry, input logic ok);
      req_type it;
      it.func = FUNC_RESPONSE;
      it.virtual_address = {$urandom, $urandom};
      it.entry_value = entry;
      it.entry_read_ok = ok;
      return it;
   endfunction

   // valid is left high after acceptance; the next call or a drain settles it
   task automatic send_item(input req_type it);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 24) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_item = it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (RESULT_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_config(input logic [63:0] root, input logic mem_valid);
      logic [63:0] data;
      data = {$urandom, $urandom};
      data[0] = mem_valid;
      wait_for_results();
      write_reg(CSR_ROOT, root);
      write_reg(CSR_VALID, data);
   endtask

   // translate, then entries until the walk ends; sometimes cut short or
   // followed by a stray entry
   task automatic send_walk();
      logic [63:0] va;
      logic [63:0] entry;
      logic        sign;
      logic        ok;
      bit          walkable;
      if ($urandom_range(99) < 85) begin
         sign = 1'($urandom_range(1));
         va = {{17{sign}}, 47'({$urandom, $urandom})};
      end else begin
         va = {$urandom, $urandom};
      end
      walkable = mem_valid_shadow && (root_shadow & FRAME_MASK) != 64'd0 &&
                 (va[63:47] == '0 || va[63:47] == '1);
      send_item(make_translate(va));
      if (walkable) begin
         for (int lvl = 0; lvl < 4; lvl++) begin
            entry = {$urandom, $urandom};
            entry[ENTRY_P] = ($urandom_range(99) < 92);
            if (lvl == 1 || lvl == 2)
               entry[ENTRY_PS] = ($urandom_range(99) < 30);
            ok = ($urandom_range(99) < 95);
            // abandon: the next translate takes over
            if ($urandom_range(99) < 3)
               break;
            send_item(make_response(entry, ok));
            if (!ok || !entry[ENTRY_P] || ((lvl == 1 || lvl == 2) && entry[ENTRY_PS]) ||
                lvl == 3)
               break;
         end
      end
      if ($urandom_range(99) < 6)
         send_item(make_response({$urandom, $urandom}, 1'($urandom_range(1))));
   endtask

   task automatic run_random_items(input int count);
      req_type it;
      int      stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 5) begin
            it = make_response({$urandom, $urandom}, 1'($urandom_range(1)));
            it.func = 1'($urandom_range(1));
            send_item(it);
         end else begin
            send_walk();
         end
      end
   endtask

   task automatic test_idle_block();
      // registers at reset: memory invalid, root zero
      send_item(make_translate(64'd0));
      send_item(make_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
   endtask

   task automatic test_register_extremes();
      set_config(64'd0, 1'b1);
      send_item(make_translate(64'h0000_0000_0000_1000));
      set_config(64'h0000_0000_0000_0FFF, 1'b1);
      send_item(make_translate(64'h0000_0000_0000_1000));
      set_config(64'hFFF0_0000_0000_0FFF, 1'b1);
      send_item(make_translate(64'h0000_0000_0000_1000));
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_item(make_translate(64'h0000_0000_0000_1000));
   endtask

   task automatic test_directed_walks();
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      // 4KB walk; size bit at the last level is ignored
      send_item(make_translate(64'd0));
      send_item(make_response(64'h0000_0123_4567_8001, 1'b1));
      send_item(make_response(64'h0000_0000_0000_1003, 1'b1));
      send_item(make_response(64'h000F_FFFF_FFFF_F001, 1'b1));
      send_item(make_response(64'h000F_FFFF_FFFF_F081, 1'b1));
      // 1GB page from all-ones entries; size bit at the top level is ignored
      send_item(make_translate(64'hFFFF_FFFF_FFFF_FFFF));
      send_item(make_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      send_item(make_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      // 2MB page
      send_item(make_translate(64'h0000_7ABC_DEF1_2345));
      send_item(make_response(64'h0000_0000_0000_2001, 1'b1));
      send_item(make_response(64'h0000_0000_0000_3001, 1'b1));
      send_item(make_response(64'h0008_0000_0040_0081, 1'b1));
      // just outside the canonical ranges
      send_item(make_translate(64'h0000_8000_0000_0000));
      send_item(make_translate(64'hFFFF_7FFF_FFFF_FFFF));
      // unreadable entry, then a non-present entry
      send_item(make_translate(64'hFFFF_8000_0000_0000));
      send_item(make_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      send_item(make_translate(64'h0000_7FFF_FFFF_FFFF));
      send_item(make_response(64'hFFFF_FFFF_FFFF_FFFE, 1'b1));
      // new translate in the middle of a walk
      send_item(make_translate(64'h0000_1234_5678_9ABC));
      send_item(make_response(64'h0000_0000_0000_5001, 1'b1));
      send_item(make_translate(64'hFFFF_8765_4321_0FED));
      send_item(make_response(64'h0000_0000_0000_6001, 1'b1));
      // a further entry, which continues the second walk
      send_item(make_response(64'h0000_0000_0000_7001, 1'b1));
   endtask

   task automatic test_random_walks();
      set_config({$urandom, $urandom} | 64'h0000_0000_0010_0000, 1'b1);
      run_random_items(120);
      // long stretch with no idling on either side
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      idle_enable = 1'b0;
      run_random_items(150);
      idle_enable = 1'b1;
      set_config(64'h0000_0000_0000_1000, 1'b1);
      run_random_items(120);
      set_config({$urandom, $urandom}, 1'b0);
      run_random_items(40);
   endtask

   task automatic test_result_backpressure();
      set_config({$urandom, $urandom} | 64'h0000_0000_0000_1000, 1'b1);
      // hold results long enough that the input side stalls
      @(negedge clock);
      rsp_hold_cycles = 120;
      run_random_items(40);
      wait_for_results();
      run_random_items(60);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ROOT;
      csr_write_data = '0;
      foreach (status_count[i])
         status_count[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_block();
      test_register_extremes();
      test_directed_walks();
      test_random_walks();
      test_result_backpressure();
      wait_for_results();

      $display("Covered %0d items: %0d entry fetches, %0d ok walks (%0d large pages)",
               items_sent, fetch_count, status_count[ST_OK], large_count);
      $display("Errors seen: unusable %0d, noncanonical %0d, unreadable %0d, %s %0d, %s %0d",
               status_count[ST_UNUSABLE], status_count[ST_NONCANON],
               status_count[ST_UNREADABLE], "not present", status_count[ST_NOTPRESENT],
               "protocol", status_count[ST_PROTOCOL]);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== four_level_page_walker.f =====
rtl/fpw_pkg.sv
rtl/fpw_front.sv
rtl/fpw_back.sv
rtl/four_level_page_walker.sv
bench/testbench.sv
